### design/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache tag model.
// No dependencies.
`default_nettype none
package sacl_pkg;

    localparam int ADDR_W = 64;
    localparam int AGE_W  = 3;
    localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

    // access kinds carried on the input tuser
    localparam logic [1:0] OP_IFETCH = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    localparam logic [3:0] RST_SET_BITS   = 4'd4;
    localparam logic [5:0] RST_BLOCK_BITS = 6'd4;
    localparam logic [3:0] RST_WAYS       = 4'd1;

    typedef struct packed {
        logic hit;
        logic evict;
    } t_acc_res;

endpackage
`default_nettype wire

### design/set_associative_cache_lru_sim.sv
// Top level of the set-associative LRU cache tag model.
// Depends on sacl_pkg, sacl_mem, sacl_update.
//
// Input stream: s_tdata carries the 64-bit address, s_tuser the access kind
// (ifetch, load, store, modify). Output stream: one transaction per data
// access, two for a modify; m_tlast marks the final one of an input item.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write set_bits, block_bits,
// ways_in_use; write only while the block is idle.
// After reset a clearing pass over every row zeroes the valid bits and
// ages; s_tready stays low meanwhile.
// Sequence: one access is address split (registered on accept), row read,
// then compare, LRU update, write back and result load; a modify runs the
// read and final step twice, an ifetch is taken without a row access. The
// row read and the write back after it set the access length. Results sit
// in an output register; a stalled m_tready holds the block in the final
// step until the register frees; a new item is taken while a result waits.
`default_nettype none
module set_associative_cache_lru_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // [63:0] address
    input  wire logic [1:0]   s_tuser,   // [1:0] opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // hit, evicted, hit_total, miss_total,
                                         // evict_total, zero pad
    output logic              m_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [5:0]   i_cfg_data
);
    localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int ROW_W = MAX_WAYS * (1 + AGE_W + ADDR_W);
    localparam logic [3:0] SB_MAX = 4'(MAX_SET_BITS);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL} t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_clr;
    logic [3:0]        r_set_bits;
    logic [5:0]        r_block_bits;
    logic [3:0]        r_ways;
    logic [ADDR_W-1:0] r_tag;
    logic [IDX_W-1:0]  r_idx;
    logic              r_second;
    logic [31:0]       r_hits, r_misses, r_evicts;
    logic              r_m_tvalid, r_m_hit, r_m_evict, r_m_last;

    logic [3:0]        w_s;
    logic [6:0]        w_sh;
    logic [ADDR_W-1:0] w_tag, w_ishift;
    logic [IDX_W-1:0]  w_mask, w_idx;
    logic [NW_W-1:0]   w_nways;
    logic              w_accept, w_load, w_mem_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [ROW_W-1:0]  w_wdata, w_rdata;
    logic [MAX_WAYS-1:0]             w_rv, w_nv;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  w_ra, w_na;
    logic [MAX_WAYS-1:0][ADDR_W-1:0] w_rt, w_nt;
    t_acc_res          w_res;

    // address split
    always_comb begin
        w_s    = (r_set_bits > SB_MAX) ? SB_MAX : r_set_bits;
        w_sh   = 7'(w_s) + 7'(r_block_bits);
        w_tag  = (w_sh >= 7'd64) ? '0 : (s_tdata >> w_sh[5:0]);
        w_ishift = s_tdata >> r_block_bits;
        for (int i = 0; i < IDX_W; i++) begin
            w_mask[i] = 4'(i) < w_s;
        end
        w_idx = w_ishift[IDX_W-1:0] & w_mask;
        if (r_ways == '0) begin
            w_nways = NW_W'(1);
        end else if (5'(r_ways) > 5'(MAX_WAYS)) begin
            w_nways = NW_W'(MAX_WAYS);
        end else begin
            w_nways = NW_W'(r_ways);
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_load   = (r_state == S_EVAL) && (!r_m_tvalid || m_tready);
    assign w_mem_we = (r_state == S_CLEAR) || w_load;
    assign w_waddr  = (r_state == S_CLEAR) ? r_clr : r_idx;
    assign w_wdata  = (r_state == S_CLEAR) ? '0 : {w_nt, w_na, w_nv};
    assign {w_rt, w_ra, w_rv} = w_rdata;

    sacl_mem #(.ADDR_BITS(IDX_W), .DATA_BITS(ROW_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == S_READ),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    sacl_update #(.MAX_WAYS(MAX_WAYS), .NW_W(NW_W)) u_update (
        .i_valid   (w_rv),
        .i_age     (w_ra),
        .i_tag     (w_rt),
        .i_req_tag (r_tag),
        .i_nways   (w_nways),
        .o_valid   (w_nv),
        .o_age     (w_na),
        .o_tag     (w_nt),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_set_bits   <= RST_SET_BITS;
            r_block_bits <= RST_BLOCK_BITS;
            r_ways       <= RST_WAYS;
            r_second     <= 1'b0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_evicts     <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:   r_set_bits   <= i_cfg_data[3:0];
                    CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                    CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                    default:        ;
                endcase
            end
            if (m_tready && !w_load) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == {IDX_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept && s_tuser != OP_IFETCH) begin
                        r_tag    <= w_tag;
                        r_idx    <= w_idx;
                        r_second <= (s_tuser == OP_MODIFY);
                        r_state  <= S_READ;
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    if (w_load) begin
                        r_m_tvalid <= 1'b1;
                        r_m_hit    <= w_res.hit;
                        r_m_evict  <= w_res.evict;
                        r_m_last   <= !r_second;
                        if (w_res.hit) begin
                            r_hits <= r_hits + 1'b1;
                        end else begin
                            r_misses <= r_misses + 1'b1;
                        end
                        if (w_res.evict) begin
                            r_evicts <= r_evicts + 1'b1;
                        end
                        // modify: second access re-reads the row just written
                        r_second <= 1'b0;
                        r_state  <= r_second ? S_READ : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tlast  = r_m_last;
    assign m_tdata  = {6'd0, r_evicts, r_misses, r_hits, r_m_evict, r_m_hit};

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_hits + r_misses) == ($past(r_hits + r_misses) + 32'd1))
        else $error("hit+miss total did not advance by one");
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid |-> !(r_m_hit && r_m_evict))
        else $error("eviction reported on a hit");
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == S_CLEAR || r_state == S_EVAL))
        else $error("row write outside clear or update step");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_m_tvalid || m_tready))
        else $error("result register overwritten");
endmodule
`default_nettype wire

### design/sacl_mem.sv
// Set row memory: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none
module sacl_mem #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 544
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [DATA_BITS-1:0] o_rdata
);
    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### design/sacl_update.sv
// Tag compare, victim choice and LRU age update for one set row.
// Depends on sacl_pkg.
`default_nettype none
module sacl_update
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int NW_W     = 5
) (
    input  wire logic [MAX_WAYS-1:0]             i_valid,
    input  wire logic [MAX_WAYS-1:0][AGE_W-1:0]  i_age,
    input  wire logic [MAX_WAYS-1:0][ADDR_W-1:0] i_tag,
    input  wire logic [ADDR_W-1:0]               i_req_tag,
    input  wire logic [NW_W-1:0]                 i_nways,
    output logic      [MAX_WAYS-1:0]             o_valid,
    output logic      [MAX_WAYS-1:0][AGE_W-1:0]  o_age,
    output logic      [MAX_WAYS-1:0][ADDR_W-1:0] o_tag,
    output t_acc_res                             o_res
);
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    logic [MAX_WAYS-1:0] w_use;
    logic                w_hit, w_inv;
    logic [WAY_W-1:0]    w_hit_w, w_inv_w, w_vic_w, w_pick;
    logic [AGE_W-1:0]    w_best;
    logic [AGE_W:0]      w_old;

    always_comb begin
        w_hit   = 1'b0;
        w_inv   = 1'b0;
        w_hit_w = '0;
        w_inv_w = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            w_use[w] = NW_W'(w) < i_nways;
            if (w_use[w] && i_valid[w] && i_tag[w] == i_req_tag) begin
                w_hit   = 1'b1;
                w_hit_w = WAY_W'(w);
            end
            if (w_use[w] && !i_valid[w]) begin
                w_inv   = 1'b1;
                w_inv_w = WAY_W'(w);
            end
        end
        // oldest way, lowest index wins ties
        w_best  = i_age[0];
        w_vic_w = '0;
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (w_use[w] && i_age[w] > w_best) begin
                w_best  = i_age[w];
                w_vic_w = WAY_W'(w);
            end
        end
        w_pick = w_hit ? w_hit_w : (w_inv ? w_inv_w : w_vic_w);
        w_old  = i_valid[w_pick] ? {1'b0, i_age[w_pick]} : {1'b1, {AGE_W{1'b0}}};

        o_valid = i_valid;
        o_age   = i_age;
        o_tag   = i_tag;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (WAY_W'(v) == w_pick) begin
                o_age[v]   = '0;
                o_valid[v] = 1'b1;
                o_tag[v]   = i_req_tag;
            end else if (w_use[v] && i_valid[v] && {1'b0, i_age[v]} < w_old
                         && i_age[v] < AGE_MAX) begin
                o_age[v] = i_age[v] + 1'b1;
            end
        end
        o_res.hit   = w_hit;
        o_res.evict = !w_hit && !w_inv;
    end
endmodule
`default_nettype wire

### test/sacl_checker.sv
// Checker for the set-associative LRU cache tag model: watches both streams,
// predicts results with its own tag/age model and compares. Depends on sacl_pkg.
`timescale 1ns / 100ps
module sacl_checker
    import sacl_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [63:0]  s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [103:0] m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_idx,
    input  wire logic [5:0]   i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);

    localparam int SETS = 256;
    localparam int WAYS = 8;

    typedef struct packed {
        logic        hit;
        logic        evict;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
    } t_cache_res;

    t_cache_res  expected_q[$];
    logic        line_vld [SETS*WAYS];
    logic [63:0] line_tg  [SETS*WAYS];
    logic [2:0]  line_ag  [SETS*WAYS];
    logic [3:0]  cur_set_bits;
    logic [5:0]  cur_block_bits;
    logic [3:0]  cur_ways;
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;

    function automatic t_cache_res lookup(input logic [63:0] addr, input logic is_last);
        int s, b, n, base, pick, best, old;
        logic found, hit, ev;
        logic [63:0] tg, ix;
        t_cache_res r;
        s = (cur_set_bits > 8) ? 8 : int'(cur_set_bits);
        b = int'(cur_block_bits);
        n = (cur_ways == 0) ? 1 : ((cur_ways > WAYS) ? WAYS : int'(cur_ways));
        tg = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
        ix = (b >= 64) ? 64'd0 : (addr >> b);
        ix = ix & ((64'd1 << s) - 64'd1);
        base = int'(ix) * WAYS;
        found = 1'b0; hit = 1'b0; ev = 1'b0; pick = 0;
        for (int w = 0; w < n; w++)
            if (!found && line_vld[base+w] && line_tg[base+w] == tg) begin
                pick = w; found = 1'b1; hit = 1'b1;
            end
        for (int w = 0; w < n; w++)
            if (!found && !line_vld[base+w]) begin
                pick = w; found = 1'b1;
            end
        if (!found) begin
            best = 0;
            for (int w = 0; w < n; w++)
                if (w == 0 || int'(line_ag[base+w]) > best) begin
                    best = int'(line_ag[base+w]); pick = w;
                end
            ev = 1'b1;
        end
        // promote: every valid way younger than the touched way ages by one, up to AGE_MAX
        old = line_vld[base+pick] ? int'(line_ag[base+pick]) : 8;
        for (int v = 0; v < n; v++)
            if (v != pick && line_vld[base+v] && int'(line_ag[base+v]) < old
                && line_ag[base+v] < AGE_MAX)
                line_ag[base+v] = line_ag[base+v] + 3'd1;
        line_ag[base+pick] = '0;
        if (hit) hit_cnt++;
        else begin
            miss_cnt++;
            if (ev) evict_cnt++;
            line_vld[base+pick] = 1'b1;
            line_tg[base+pick] = tg;
        end
        r = '{hit, ev, is_last, hit_cnt, miss_cnt, evict_cnt};
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cache_res exp_r, got;
        if (!i_rst_n) begin
            cur_set_bits <= RST_SET_BITS;
            cur_block_bits <= RST_BLOCK_BITS;
            cur_ways <= RST_WAYS;
            hit_cnt = 0; miss_cnt = 0; evict_cnt = 0;
            for (int i = 0; i < SETS*WAYS; i++) begin
                line_vld[i] = 1'b0; line_ag[i] = '0;
            end
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:   cur_set_bits <= i_cfg_data[3:0];
                    CFG_BLOCK_BITS: cur_block_bits <= i_cfg_data;
                    CFG_WAYS:       cur_ways <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_MODIFY) begin
                    expected_q.push_back(lookup(s_tdata, 1'b0));
                    expected_q.push_back(lookup(s_tdata, 1'b1));
                end else if (s_tuser != OP_IFETCH)
                    expected_q.push_back(lookup(s_tdata, 1'b1));
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[0], m_tdata[1], m_tlast, m_tdata[33:2],
                        m_tdata[65:34], m_tdata[97:66]};
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== got) begin
                        if (o_errors < 10)
                            $display("result mismatch: exp %h got %h", exp_r, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

### test/tb.sv
// Stimulus top for the set-associative LRU cache tag model: drives accesses,
// configuration phases and back-pressure. Depends on sacl_pkg, sacl_checker.
`timescale 1ns / 100ps
module tb;
    import sacl_pkg::*;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = 0;
    logic [1:0]   s_tuser = OP_IFETCH;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         i_cfg_we = 0;
    logic [1:0]   i_cfg_idx = CFG_SET_BITS;
    logic [5:0]   i_cfg_data = 0;
    int           errors, pending, results;
    int           sent = 0;
    logic         long_hold = 0;
    logic [63:0]  hot_addr [16];

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    set_associative_cache_lru_sim i_dut (.*);

    sacl_checker i_chk (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // receiver stall pattern, with one long hold-off on request
    always @(negedge i_clk) begin
        if (long_hold) m_tready <= 0;
        else if (sent % 400 < 100) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send(input logic [1:0] op, input logic [63:0] addr);
        s_tvalid <= 1; s_tuser <= op; s_tdata <= addr;
        do @(posedge i_clk); while (!s_tready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic gap();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [5:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(input int count);
        int burst;
        logic [1:0] op;
        logic [63:0] a;
        for (int i = 0; i < count; i++) begin
            op = 2'($urandom_range(0, 3));
            // mostly reuse a small pool so sets fill and evict
            a = ($urandom_range(0, 9) < 8) ? hot_addr[$urandom_range(0, 15)] : rnd64();
            send(op, a);
            if ($urandom_range(0, 7) == 0) gap();
        end
    endtask

    task automatic new_pool(input int span);
        for (int i = 0; i < 16; i++)
            hot_addr[i] = ($urandom_range(0, 1) ? 64'd0 : {$urandom(), 32'd0})
                          | ($urandom() % span);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        // directed: extremes and every access kind at reset settings
        send(OP_IFETCH, 64'h0);
        send(OP_LOAD, 64'h0);
        send(OP_LOAD, 64'h0);
        send(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send(OP_MODIFY, 64'h0000_0000_0000_0100);
        send(OP_MODIFY, 64'h8000_0000_0000_0000);
        send(OP_LOAD, 64'h5555_5555_5555_5555);
        send(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
        drain();
        // saturating set bits, zero ways, wide offset
        write_cfg(CFG_SET_BITS, 6'd15);
        write_cfg(CFG_WAYS, 6'd0);
        write_cfg(CFG_BLOCK_BITS, 6'd60);
        send(OP_LOAD, 64'hF000_0000_0000_0000);
        send(OP_LOAD, 64'h1000_0000_0000_0000);
        send(OP_MODIFY, 64'h1234);
        drain();
        write_cfg(CFG_BLOCK_BITS, 6'd63);
        write_cfg(CFG_WAYS, 6'd15);
        for (int i = 0; i < 10; i++) send(OP_LOAD, {i[3:0], 60'd0});
        drain();
        // reduce ways: stale aged lines stay, exercises age ties
        write_cfg(CFG_WAYS, 6'd3);
        send(OP_LOAD, 64'h0);
        send(OP_STORE, 64'hFFFF_0000_0000_0000);
        drain();
        write_cfg(CFG_BLOCK_BITS, 6'd32);
        send(OP_LOAD, 64'h1);
        drain();
        // random phases through several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(CFG_SET_BITS, (ph == 0) ? 6'd0 : 6'($urandom_range(0, 9)));
            write_cfg(CFG_BLOCK_BITS, (ph == 1) ? 6'd0 : 6'($urandom_range(0, 12)));
            write_cfg(CFG_WAYS, (ph == 2) ? 6'd8 : 6'($urandom_range(1, 8)));
            new_pool(1 << $urandom_range(6, 16));
            if (ph == 3) begin
                fork
                    begin
                        long_hold = 1;
                        repeat (300) @(negedge i_clk);
                        long_hold = 0;
                    end
                    random_phase(40);
                join
                random_phase(150);
            end else random_phase(190);
            drain();
        end
        $display("covered %0d input transactions, %0d results: directed corner settings",
                 sent, results);
        $display("then 8 random cache configurations with back-pressure and a long stall");
        if (errors == 0) $display("set_associative_cache_lru_sim: match");
        else $display("set_associative_cache_lru_sim: mismatch");
        $finish;
    end

    initial begin
        #5000000;
        $display("set_associative_cache_lru_sim: mismatch");
        $finish;
    end

endmodule

### sim.f
design/sacl_pkg.sv
design/sacl_mem.sv
design/sacl_update.sv
design/set_associative_cache_lru_sim.sv
test/sacl_checker.sv
test/tb.sv
